// File: hdl/fixed_point_q24_8_alu_assert.svh
// Assertion macros for the Q24.8 arithmetic unit
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

`ifndef SYNTHESIS
`define FXA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("fxa assertion failed");
`define FXA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fxa assertion failed");
`else
`define FXA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FXA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/fxa_pkg.sv
// Shared types and constants for the Q24.8 arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
package fxa_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 8;
    localparam int DIV_W     = WORD_W + FRAC_BITS;   // quotient bits
    localparam int WORK_W    = WORD_W + DIV_W;       // remainder and dividend
    localparam int PROD_W    = 2 * WORD_W;
    localparam int MAG_W     = PROD_W - FRAC_BITS;   // rounded product magnitude
    localparam int LATENCY   = DIV_W + 3;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_GT, OP_LE, OP_GE,
        OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_FROM_INT, OP_TO_INT
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        t_op                      operation;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] result_value;
        logic                     compare_true;
        t_status                  status;
    } t_resp;

    // sideband that travels beside the divider
    typedef struct packed {
        t_op                      op;
        logic signed [WORD_W-1:0] value;
        logic                     flag;
        t_status                  status;
        logic                     q_neg;
        logic                     a_neg;
        logic                     a_zero;
        logic                     b_zero;
    } t_side;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        t_status                  status;
    } t_sat;

endpackage
`default_nettype wire

// File: hdl/fixed_point_q24_8_alu.sv
// Top level of the pipelined Q24.8 arithmetic unit
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy stays low: the unit takes one request every cycle.
//   i_req carries the operation and two raw Q24.8 operands.
//   Each request yields exactly one response: o_done is high for one cycle
//   with o_resp, in request order. The receiver cannot hold responses off.
// Pipeline: every operation takes the same path. One input register, one
//   divider stage per quotient bit (40), one rounding stage and one output
//   register lie between request and response; multiply uses three of the
//   divider-aligned stages. Throughput is one request per cycle.
// Reset (synchronous, i_rst_n low) drops every request in flight; no
//   response comes out for them. Operand payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_q24_8_alu_assert.svh"
module fixed_point_q24_8_alu import fxa_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire t_req  i_req,
    output logic       busy,
    output logic       o_done,
    output t_resp      o_resp
);

    localparam int MUL_JOIN = 3;
    localparam logic [MAG_W-1:0] MAG_MIN = {{(MAG_W-WORD_W){1'b0}}, WORD_MIN};
    localparam logic [MAG_W-1:0] MAG_MAX = {{(MAG_W-WORD_W){1'b0}}, WORD_MAX};
    localparam logic [DIV_W:0]   QR_MIN  = {{(DIV_W+1-WORD_W){1'b0}}, WORD_MIN};
    localparam logic [DIV_W:0]   QR_MAX  = {{(DIV_W+1-WORD_W){1'b0}}, WORD_MAX};
    localparam logic [PROD_W-1:0] HALF   = PROD_W'(1) << (FRAC_BITS - 1);

    // stage 1: input register
    logic                     r_v1;
    t_op                      r_op;
    logic signed [WORD_W-1:0] r_a;
    logic signed [WORD_W-1:0] r_b;

    // divider-aligned line
    logic [DIV_W-1:0] r_vd;
    t_side            r_side [DIV_W];
    t_side            n_side0;
    t_side            n_join;

    // multiply path
    logic signed [PROD_W-1:0] r_mp;
    logic [PROD_W-1:0]        r_mm;
    logic                     r_mneg1;
    logic [MAG_W-1:0]         r_mr;
    logic                     r_mneg2;

    // divider ports
    logic [DIV_W-1:0]  n_num;
    logic [WORD_W-1:0] n_den;
    logic [DIV_W-1:0]  w_quo;
    logic [WORD_W-1:0] w_rem;
    logic [WORD_W-1:0] w_dvs;

    // rounding stage and output
    logic           r_vf;
    logic [DIV_W:0] r_qr;
    t_side          r_fside;
    logic           r_done;
    t_resp          r_resp;
    t_resp          n_resp;

    assign busy = 1'b0;

    function automatic t_sat sat33(input logic signed [WORD_W:0] s);
        t_sat r;
        if (s[WORD_W] != s[WORD_W-1]) begin
            r.value  = s[WORD_W] ? WORD_MIN : WORD_MAX;
            r.status = ST_OVF;
        end else begin
            r.value  = s[WORD_W-1:0];
            r.status = ST_OK;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
        end
        r_op <= i_req.operation;
        r_a  <= i_req.operand_a;
        r_b  <= i_req.operand_b;
    end

    // operations other than multiply and divide, evaluated combinationally from stage 1
    always_comb begin
        logic signed [WORD_W:0]       ext_a;
        logic signed [WORD_W:0]       ext_b;
        logic [FRAC_BITS:0]           hi;
        logic [WORD_W-1:0]            mag_a;
        t_sat                         s;
        ext_a = {r_a[WORD_W-1], r_a};
        ext_b = {r_b[WORD_W-1], r_b};
        hi    = r_a[WORD_W-1 -: FRAC_BITS+1];
        mag_a = r_a[WORD_W-1] ? WORD_W'(-r_a) : WORD_W'(r_a);
        s.value  = '0;
        s.status = ST_OK;
        n_side0.flag = 1'b0;
        unique case (r_op)
            OP_ADD:  s = sat33(ext_a + ext_b);
            OP_SUB:  s = sat33(ext_a - ext_b);
            OP_INC:  s = sat33(ext_a + (WORD_W+1)'(1));
            OP_DEC:  s = sat33(ext_a - (WORD_W+1)'(1));
            OP_LT:   n_side0.flag = (r_a <  r_b);
            OP_GT:   n_side0.flag = (r_a >  r_b);
            OP_LE:   n_side0.flag = (r_a <= r_b);
            OP_GE:   n_side0.flag = (r_a >= r_b);
            OP_EQ:   n_side0.flag = (r_a == r_b);
            OP_NE:   n_side0.flag = (r_a != r_b);
            OP_MIN:  s.value = (r_a < r_b) ? r_a : r_b;
            OP_MAX:  s.value = (r_a > r_b) ? r_a : r_b;
            OP_FROM_INT: begin
                if (hi == '0 || hi == '1) begin
                    s.value = r_a <<< FRAC_BITS;
                end else begin
                    s.value  = r_a[WORD_W-1] ? WORD_MIN : WORD_MAX;
                    s.status = ST_OVF;
                end
            end
            OP_TO_INT: s.value = r_a >>> FRAC_BITS;
            OP_MUL, OP_DIV: s.value = '0;
            default: s.value = '0;
        endcase
        n_side0.op     = r_op;
        n_side0.value  = s.value;
        n_side0.status = s.status;
        n_side0.q_neg  = r_a[WORD_W-1] ^ r_b[WORD_W-1];
        n_side0.a_neg  = r_a[WORD_W-1];
        n_side0.a_zero = (r_a == '0);
        n_side0.b_zero = (r_b == '0);
        n_num = {mag_a, {FRAC_BITS{1'b0}}};
        n_den = r_b[WORD_W-1] ? WORD_W'(-r_b) : WORD_W'(r_b);
    end

    fxa_div u_div (
        .i_clk (i_clk),
        .i_num (n_num),
        .i_den (n_den),
        .o_quo (w_quo),
        .o_rem (w_rem),
        .o_den (w_dvs)
    );

    // multiply: product, magnitude, rounding, then clamp into the line
    always_ff @(posedge i_clk) begin
        r_mp    <= r_a * r_b;
        r_mm    <= r_mp[PROD_W-1] ? PROD_W'(-r_mp) : PROD_W'(r_mp);
        r_mneg1 <= r_mp[PROD_W-1];
        r_mr    <= MAG_W'((r_mm + HALF) >> FRAC_BITS);
        r_mneg2 <= r_mneg1;
    end

    always_comb begin
        n_join = r_side[MUL_JOIN-1];
        if (r_side[MUL_JOIN-1].op == OP_MUL) begin
            n_join.status = ST_OK;
            if (r_mneg2) begin
                if (r_mr > MAG_MIN) begin
                    n_join.value  = WORD_MIN;
                    n_join.status = ST_OVF;
                end else begin
                    n_join.value = WORD_W'(-r_mr[WORD_W-1:0]);
                end
            end else begin
                if (r_mr > MAG_MAX) begin
                    n_join.value  = WORD_MAX;
                    n_join.status = ST_OVF;
                end else begin
                    n_join.value = r_mr[WORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else begin
            r_vd <= {r_vd[DIV_W-2:0], r_v1};
        end
        r_side[0] <= n_side0;
        for (int i = 1; i < DIV_W; i++) begin
            if (i == MUL_JOIN) begin
                r_side[i] <= n_join;
            end else begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // round half away from zero on the quotient magnitude
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else begin
            r_vf <= r_vd[DIV_W-1];
        end
        r_qr    <= {1'b0, w_quo} + (DIV_W+1)'({w_rem, 1'b0} >= {1'b0, w_dvs});
        r_fside <= r_side[DIV_W-1];
    end

    always_comb begin
        n_resp.result_value = r_fside.value;
        n_resp.compare_true = r_fside.flag;
        n_resp.status       = r_fside.status;
        if (r_fside.op == OP_DIV) begin
            if (r_fside.b_zero) begin
                n_resp.status = ST_DIV0;
                if (r_fside.a_zero) begin
                    n_resp.result_value = '0;
                end else begin
                    n_resp.result_value = r_fside.a_neg ? WORD_MIN : WORD_MAX;
                end
            end else if (r_fside.q_neg) begin
                if (r_qr > QR_MIN) begin
                    n_resp.result_value = WORD_MIN;
                    n_resp.status       = ST_OVF;
                end else begin
                    n_resp.result_value = WORD_W'(-r_qr[WORD_W-1:0]);
                end
            end else begin
                if (r_qr > QR_MAX) begin
                    n_resp.result_value = WORD_MAX;
                    n_resp.status       = ST_OVF;
                end else begin
                    n_resp.result_value = r_qr[WORD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vf;
        end
        r_resp <= n_resp;
    end

    assign o_done = r_done;
    assign o_resp = r_resp;

    `FXA_ASSERT_IMP(a_req_yields_resp, i_clk, i_rst_n, start && !busy, ##LATENCY o_done)
    `FXA_ASSERT_IMP(a_resp_has_req, i_clk, i_rst_n, o_done, $past(start, LATENCY))
    `FXA_ASSERT_IMP(a_flag_clean, i_clk, i_rst_n, o_done && o_resp.compare_true,
        (o_resp.result_value == '0 && o_resp.status == ST_OK))
    `FXA_ASSERT_NEXT(a_mul_align, i_clk, i_rst_n, r_vd[MUL_JOIN-1], r_vd[MUL_JOIN])

endmodule
`default_nettype wire

// File: hdl/fxa_div.sv
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module fxa_div import fxa_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic [DIV_W-1:0]  i_num,
    input  wire logic [WORD_W-1:0] i_den,
    output logic      [DIV_W-1:0]  o_quo,
    output logic      [WORD_W-1:0] o_rem,
    output logic      [WORD_W-1:0] o_den
);

    logic [WORK_W-1:0] r_work [DIV_W];
    logic [WORD_W-1:0] r_den  [DIV_W];

    function automatic logic [WORK_W-1:0] div_step(input logic [WORK_W-1:0] w,
                                                   input logic [WORD_W-1:0] d);
        logic [WORK_W:0] t;
        logic [WORD_W:0] top;
        logic [WORD_W:0] diff;
        logic            q;
        t    = {w, 1'b0};
        top  = t[WORK_W:DIV_W];
        q    = (top >= {1'b0, d});
        diff = q ? (top - {1'b0, d}) : top;
        return {diff[WORD_W-1:0], t[DIV_W-1:1], q};
    endfunction

    for (genvar i = 0; i < DIV_W; i++) begin : g_stage
        if (i == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_work[i] <= div_step({{WORD_W{1'b0}}, i_num}, i_den);
                r_den[i]  <= i_den;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_work[i] <= div_step(r_work[i-1], r_den[i-1]);
                r_den[i]  <= r_den[i-1];
            end
        end
    end

    assign o_quo = r_work[DIV_W-1][DIV_W-1:0];
    assign o_rem = r_work[DIV_W-1][WORK_W-1:DIV_W];
    assign o_den = r_den[DIV_W-1];

endmodule
`default_nettype wire
